### rtl/sjgl_pkg.sv
package sjgl_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned TextW   = 8;
  localparam int unsigned IndexW  = 14;
  localparam int unsigned OffsetW = 20;
  localparam int unsigned PenW    = 16;

  localparam logic [OffsetW-1:0] WideBaseReset = OffsetW'(288 * 36);

  typedef struct packed {
    logic              clr;
    logic              emit;
    logic              wide;
    logic [IndexW-1:0] idx;
  } glyph_cmd_t;

endpackage

### rtl/sjis_text_glyph_locator.sv
// Channel   Handshake                   Payload
// text in   in_valid_i / in_stall_o     text_byte_i, string_start_i
// glyph out out_valid_o / out_stall_i   wide_glyph_o, glyph_index_o, rom_offset_o, pen_x_o
// config    cfg_we_i                    cfg_wdata_i (wide_glyph_base)
//
// One text byte per cycle while the command queue has room; a glyph for a trail
// or single byte passes the front decode, the command queue and the output register.
// The front stalls only when the QueueDepth-entry command queue is full.
// A held output transfer stalls the back; the queue absorbs the front meanwhile.
// Reset clears the pending lead, the pen and the queue; the wide base returns to 10368.
module sjis_text_glyph_locator #(
  parameter int unsigned QueueDepth = sjgl_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sjgl_pkg::OffsetW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sjgl_pkg::TextW-1:0]    text_byte_i,
  input  logic                          string_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          wide_glyph_o,
  output logic [sjgl_pkg::IndexW-1:0]   glyph_index_o,
  output logic [sjgl_pkg::OffsetW-1:0]  rom_offset_o,
  output logic [sjgl_pkg::PenW-1:0]     pen_x_o
);
  import sjgl_pkg::*;

  logic       q_full, q_empty, q_push, q_pop;
  glyph_cmd_t push_cmd, head_cmd;

  sjgl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .string_start_i (string_start_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  sjgl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty)
  );

  sjgl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_i        (head_cmd),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .wide_glyph_o  (wide_glyph_o),
    .glyph_index_o (glyph_index_o),
    .rom_offset_o  (rom_offset_o),
    .pen_x_o       (pen_x_o)
  );

endmodule

### rtl/sjgl_front.sv
module sjgl_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sjgl_pkg::TextW-1:0]  text_byte_i,
  input  logic                        string_start_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output sjgl_pkg::glyph_cmd_t        q_cmd_o
);
  import sjgl_pkg::*;

  localparam logic [7:0] BlankGlyph = 8'd96;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  logic             lead_pending_q, lead_pending_d;
  logic [7:0]       held_lead_q;
  logic             take;
  logic             pend_eff;
  logic             is_zero;
  logic             lead_b;
  logic [8:0]       half_idx;
  logic             trail_ok;
  logic [7:0]       row0, row1, row2, cell0, cell1;
  logic [6:0]       row_rel, cell_rel;
  logic [13:0]      wide_idx;
  glyph_cmd_t       cmd;

  assign in_stall_o = q_full_i;
  assign take       = in_valid_i & ~in_stall_o;
  assign pend_eff   = lead_pending_q & ~string_start_i;
  assign is_zero    = (text_byte_i == 8'h00);
  assign lead_b     = is_lead(text_byte_i);

  always_comb begin
    if (text_byte_i < 8'd33 || text_byte_i == 8'd127) begin
      half_idx = {1'b0, BlankGlyph};
    end else if (text_byte_i <= 8'd126) begin
      half_idx = {1'b0, text_byte_i - 8'd32};
    end else if (text_byte_i == 8'd128) begin
      half_idx = 9'd95;
    end else if (text_byte_i >= 8'd160) begin
      half_idx = {1'b0, text_byte_i} + 9'd32;
    end else begin
      half_idx = {1'b0, BlankGlyph};
    end
  end

  // Shift-JIS pair to JIS row/cell, rows from 0x30 folded down by 8
  always_comb begin
    trail_ok = (text_byte_i >= 8'h40) && (text_byte_i <= 8'hFC) &&
               (text_byte_i != 8'h7F) && is_lead(held_lead_q);
    row0  = held_lead_q - ((held_lead_q <= 8'h9F) ? 8'h71 : 8'hB1);
    row1  = {row0[6:0], 1'b1};
    cell0 = (text_byte_i > 8'h7F) ? text_byte_i - 8'd1 : text_byte_i;
    if (cell0 >= 8'h9E) begin
      cell1 = cell0 - 8'h7D;
      row2  = row1 + 8'd1;
    end else begin
      cell1 = cell0 - 8'h1F;
      row2  = row1;
    end
    if (row2 >= 8'h30) begin
      row2 = row2 - 8'd8;
    end
    row_rel  = 7'(row2 - 8'h21);
    cell_rel = 7'(cell1 - 8'h21);
    wide_idx = trail_ok ? 14'(row_rel * 14'd94) + {7'd0, cell_rel} : '0;
  end

  always_comb begin
    cmd.clr  = string_start_i | is_zero;
    cmd.emit = ~is_zero & (pend_eff | ~lead_b);
    cmd.wide = pend_eff;
    cmd.idx  = pend_eff ? wide_idx : {5'd0, half_idx};
  end

  assign q_push_o       = take & (cmd.clr | cmd.emit);
  assign q_cmd_o        = cmd;
  assign lead_pending_d = ~is_zero & ~pend_eff & lead_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
    end else if (take) begin
      lead_pending_q <= lead_pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && lead_pending_d) begin
      held_lead_q <= text_byte_i;
    end
  end

  a_lead_held_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_pending_q |-> is_lead(held_lead_q))
    else $error("pending lead is not a lead byte");

endmodule

### rtl/sjgl_queue.sv
module sjgl_queue #(
  parameter int unsigned Depth = sjgl_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sjgl_pkg::glyph_cmd_t  push_cmd_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output sjgl_pkg::glyph_cmd_t  head_o,
  output logic                  empty_o
);
  import sjgl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  glyph_cmd_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count past depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

endmodule

### rtl/sjgl_back.sv
module sjgl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sjgl_pkg::OffsetW-1:0]  cfg_wdata_i,
  input  sjgl_pkg::glyph_cmd_t          head_i,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          wide_glyph_o,
  output logic [sjgl_pkg::IndexW-1:0]   glyph_index_o,
  output logic [sjgl_pkg::OffsetW-1:0]  rom_offset_o,
  output logic [sjgl_pkg::PenW-1:0]     pen_x_o
);
  import sjgl_pkg::*;

  localparam logic [PenW:0] HalfAdvance = (PenW+1)'(14);
  localparam logic [PenW:0] WideAdvance = (PenW+1)'(26);

  logic [OffsetW-1:0] base_q;
  logic [PenW-1:0]    pen_q, pen_d, pen_cur;
  logic [PenW:0]      pen_sum;
  logic               out_valid_q;
  logic               out_free;
  logic               pop;
  logic               emit;
  logic [OffsetW-1:0] offset;
  logic [OffsetW-1:0] wide_off;
  logic [OffsetW-1:0] half_off;

  logic               wide_q;
  logic [IndexW-1:0]  index_q;
  logic [OffsetW-1:0] offset_q;
  logic [PenW-1:0]    pen_x_q;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop      = ~q_empty_i & (~head_i.emit | out_free);
  assign emit     = pop & head_i.emit;
  assign q_pop_o  = pop;

  assign pen_cur  = head_i.clr ? '0 : pen_q;
  assign pen_sum  = {1'b0, pen_cur} + (head_i.wide ? WideAdvance : HalfAdvance);
  assign pen_d    = pen_sum[PenW] ? '1 : pen_sum[PenW-1:0];

  assign wide_off = base_q + OffsetW'({7'd0, head_i.idx} * 21'd72);
  assign half_off = OffsetW'({6'd0, head_i.idx} * 20'd36);
  assign offset   = head_i.wide ? wide_off : half_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= WideBaseReset;
      pen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (pop) begin
        pen_q <= head_i.emit ? pen_d : pen_cur;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      wide_q   <= head_i.wide;
      index_q  <= head_i.idx;
      offset_q <= offset;
      pen_x_q  <= pen_cur;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wide_glyph_o  = wide_q;
  assign glyph_index_o = index_q;
  assign rom_offset_o  = offset_q;
  assign pen_x_o       = pen_x_q;

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("glyph issued over an untaken transfer");

  a_pen_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !head_i.clr && pen_q != '1) |=> pen_q > $past(pen_q))
    else $error("pen did not advance");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sjgl_pkg::*;

  typedef struct {
    logic [TextW-1:0] text_byte;
    logic             string_start;
    int unsigned      gap;
    bit               drain;
  } text_item_t;

  typedef struct {
    logic               wide;
    logic [IndexW-1:0]  glyph_index;
    logic [OffsetW-1:0] rom_offset;
    logic [PenW-1:0]    pen_x;
  } glyph_t;

  localparam int unsigned HalfBytes   = 12 * 24 / 8;
  localparam int unsigned WideBytes   = 24 * 24 / 8;
  localparam int unsigned HalfAdvance = 14;
  localparam int unsigned WideAdvance = 26;
  localparam int unsigned BlankGlyph  = 96;
  localparam int unsigned PenMax      = 65535;
  localparam int unsigned OffsetMax   = (1 << OffsetW) - 1;
  localparam int unsigned HoldCycles  = 300;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [OffsetW-1:0] cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [TextW-1:0]   text_byte_i    = '0;
  logic               string_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic               wide_glyph_o;
  logic [IndexW-1:0]  glyph_index_o;
  logic [OffsetW-1:0] rom_offset_o;
  logic [PenW-1:0]    pen_x_o;

  sjis_text_glyph_locator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .string_start_i (string_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .wide_glyph_o   (wide_glyph_o),
    .glyph_index_o  (glyph_index_o),
    .rom_offset_o   (rom_offset_o),
    .pen_x_o        (pen_x_o)
  );

  text_item_t  text_q[$];
  glyph_t      glyph_q[$];

  // predictor state
  logic [OffsetW-1:0] wide_base = WideBaseReset;
  bit                 lead_wait = 1'b0;
  logic [TextW-1:0]   lead_byte = '0;
  int unsigned        pen       = 0;

  int unsigned errors       = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_sent   = 0;
  int unsigned glyphs_seen  = 0;
  int unsigned half_cnt     = 0;
  int unsigned wide_cnt     = 0;
  int unsigned bad_cnt      = 0;
  int unsigned term_cnt     = 0;
  int unsigned dropped_cnt  = 0;
  int unsigned sat_cnt      = 0;
  int unsigned wrap_cnt     = 0;

  bit          tx_idle    = 1'b1;
  bit          rx_idle    = 1'b1;
  bit          rx_calm    = 1'b0;
  bit          drain_next = 1'b0;
  int unsigned gap_cnt    = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_req   = 0;
  int unsigned hold_seen  = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

  function automatic bit is_lead_byte(logic [TextW-1:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  function automatic bit bad_trail(logic [TextW-1:0] t);
    return t < 8'h40 || t > 8'hFC || t == 8'h7F;
  endfunction

  function automatic int unsigned kanji_index(logic [TextW-1:0] lead, logic [TextW-1:0] t);
    int unsigned row;
    int unsigned col;
    if (!is_lead_byte(lead) || bad_trail(t)) return 0;
    row  = lead - ((lead <= 8'h9F) ? 8'h71 : 8'hB1);
    row  = row * 2 + 1;
    col  = t;
    if (col > 8'h7F) col = col - 1;
    if (col >= 8'h9E) begin
      col  = col - 8'h7D;
      row  = row + 1;
    end else begin
      col  = col - 8'h1F;
    end
    if (row >= 8'h30) row = row - 8;
    return (row - 8'h21) * 94 + (col - 8'h21);
  endfunction

  function automatic int unsigned half_index(logic [TextW-1:0] b);
    if (b < 33 || b == 127) return BlankGlyph;
    if (b <= 126) return b - 32;
    if (b == 128) return 95;
    if (b >= 160) return b - 160 + 192;
    return BlankGlyph;
  endfunction

  task automatic locate_glyph(logic [TextW-1:0] b, logic s);
    glyph_t      g;
    bit          wide;
    int unsigned idx;
    int unsigned off;
    int unsigned adv;
    if (s) begin
      lead_wait = 1'b0;
      pen       = 0;
    end
    if (b == 0) begin
      if (lead_wait) dropped_cnt++;
      lead_wait = 1'b0;
      pen       = 0;
      term_cnt++;
      return;
    end
    if (lead_wait) begin
      lead_wait = 1'b0;
      wide      = 1'b1;
      idx       = kanji_index(lead_byte, b);
      if (bad_trail(b)) bad_cnt++;
    end else if (is_lead_byte(b)) begin
      lead_byte = b;
      lead_wait = 1'b1;
      return;
    end else begin
      wide = 1'b0;
      idx  = half_index(b);
    end
    if (wide) begin
      off = wide_base + idx * WideBytes;
      if (off > OffsetMax) wrap_cnt++;
      adv = WideAdvance;
      wide_cnt++;
    end else begin
      off = idx * HalfBytes;
      adv = HalfAdvance;
      half_cnt++;
    end
    g.wide        = wide;
    g.glyph_index = idx[IndexW-1:0];
    g.rom_offset  = off[OffsetW-1:0];
    g.pen_x       = pen[PenW-1:0];
    glyph_q.push_back(g);
    pen = pen + adv;
    if (pen > PenMax) begin
      pen = PenMax;
      sat_cnt++;
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    text_item_t cur;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      text_byte_i    <= '0;
      string_start_i <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        locate_glyph(text_byte_i, string_start_i);
        bytes_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (text_q.size() == 0 || (text_q[0].drain && glyph_q.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else if (gap_cnt < text_q[0].gap) begin
          gap_cnt++;
          in_valid_i <= 1'b0;
        end else begin
          cur     = text_q.pop_front();
          gap_cnt = 0;
          in_valid_i     <= 1'b1;
          text_byte_i    <= cur.text_byte;
          string_start_i <= cur.string_start;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    glyph_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        glyphs_seen++;
        if (glyph_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected glyph, actual wide %0h index %0h offset %0h pen %0h",
                   $time, wide_glyph_o, glyph_index_o, rom_offset_o, pen_x_o);
        end else begin
          want = glyph_q.pop_front();
          check_field("wide_glyph", want.wide, wide_glyph_o);
          check_field("glyph_index", want.glyph_index, glyph_index_o);
          check_field("rom_offset", want.rom_offset, rom_offset_o);
          check_field("pen_x", want.pen_x, pen_x_o);
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        stall_left = (rx_idle && !rx_calm) ? $urandom_range(0, 11) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      out_stall_i <= (hold_left > 0) || (stall_left > 0);
    end
  end

  task automatic wait_idle();
    @(negedge clk_i);
    while (text_q.size() != 0 || in_valid_i || glyph_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_base(logic [OffsetW-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wide_base = v;
    @(negedge clk_i);
  endtask

  task automatic add_byte(logic [TextW-1:0] b, logic s);
    text_item_t it;
    it.text_byte    = b;
    it.string_start = s;
    it.gap          = tx_idle ? $urandom_range(0, 11) : 0;
    it.drain        = drain_next;
    drain_next      = 1'b0;
    text_q.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [TextW-1:0] pick_lead();
    if ($urandom_range(0, 1)) return 8'($urandom_range(8'h81, 8'h9F));
    return 8'($urandom_range(8'hE0, 8'hFC));
  endfunction

  function automatic logic [TextW-1:0] pick_trail();
    logic [TextW-1:0] t;
    do t = 8'($urandom_range(8'h40, 8'hFC)); while (t == 8'h7F);
    return t;
  endfunction

  function automatic logic [TextW-1:0] pick_bad_trail();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(8'h00, 8'h3F));
      1: return 8'h7F;
      default: return 8'($urandom_range(8'hFD, 8'hFF));
    endcase
  endfunction

  task automatic add_string(int unsigned n, bit noisy);
    logic        s;
    int unsigned sel;
    s = noisy ? 1'($urandom_range(0, 1)) : 1'b1;
    for (int unsigned k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (noisy && $urandom_range(0, 7) == 0) begin
        add_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
      if (sel < 40) begin
        add_byte(8'($urandom_range(8'h21, 8'h7E)), s);
      end else if (sel < 50) begin
        case ($urandom_range(0, 2))
          0: add_byte(8'($urandom_range(8'hA0, 8'hDF)), s);
          1: add_byte(8'($urandom_range(8'hFD, 8'hFF)), s);
          default: add_byte(8'h80, s);
        endcase
      end else if (sel < 58) begin
        add_byte(($urandom_range(0, 3) == 0) ? 8'h7F : 8'($urandom_range(1, 8'h20)), s);
      end else if (sel < 90) begin
        add_byte(pick_lead(), s);
        add_byte(pick_trail(), 1'b0);
      end else if (sel < 96) begin
        add_byte(pick_lead(), s);
        add_byte(pick_bad_trail(), 1'b0);
      end else begin
        add_byte(8'($urandom), s);
      end
      s = 1'b0;
    end
    if ($urandom_range(0, 4) != 0) add_byte(8'h00, 1'b0);
  endtask

  task automatic add_random(int unsigned count, bit noisy, bit mix_idle, bit drains);
    int unsigned stop;
    int unsigned strings;
    stop    = bytes_queued + count;
    strings = 0;
    while (bytes_queued < stop) begin
      if (mix_idle) tx_idle = ($urandom_range(0, 3) != 0);
      if (drains && strings % 5 == 4) drain_next = 1'b1;
      add_string($urandom_range(1, 16), noisy);
      strings++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset base
    add_byte(8'h41, 1'b1);
    add_byte(8'h20, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h7E, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h81, 1'b0);
    add_byte(8'h40, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(8'hFC, 1'b0);
    add_byte(8'hE0, 1'b0);
    add_byte(8'h9E, 1'b0);
    add_byte(8'hFC, 1'b0);
    add_byte(8'hFC, 1'b0);
    add_byte(8'h88, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'hE0, 1'b0);
    add_byte(8'h3F, 1'b0);
    add_byte(8'hE0, 1'b0);
    add_byte(8'hFD, 1'b0);
    add_byte(8'h81, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'h42, 1'b1);

    // top base: wide offsets wrap
    write_base(20'hFFFFF);
    add_random(200, 1'b0, 1'b1, 1'b0);

    // zero base, receiver holds off while sender streams
    write_base('0);
    tx_idle = 1'b0;
    add_random(100, 1'b0, 1'b0, 1'b0);
    hold_req++;

    write_base(20'($urandom_range(0, OffsetMax)));
    tx_idle = 1'b1;
    add_random(150, 1'b1, 1'b1, 1'b1);

    // one long string of wide glyphs, back to back
    write_base(WideBaseReset);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    add_byte(pick_lead(), 1'b1);
    add_byte(pick_trail(), 1'b0);
    for (int k = 1; k < 40; k++) begin
      add_byte(pick_lead(), 1'b0);
      add_byte(pick_trail(), 1'b0);
    end
    for (int k = 0; k < 4; k++) add_byte(8'h5A, 1'b0);
    add_byte(8'h00, 1'b0);

    write_base(20'($urandom_range(0, OffsetMax)));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    add_random(50, 1'b1, 1'b1, 1'b0);

    wait_idle();
    $display("Run: %0d bytes in, %0d glyphs out (%0d half, %0d wide, %0d bad trails)",
             bytes_sent, glyphs_seen, half_cnt, wide_cnt, bad_cnt);
    $display("     %0d terminators, %0d dropped leads, %0d pen clamps, %0d offset wraps",
             term_cnt, dropped_cnt, sat_cnt, wrap_cnt);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sjgl_pkg.sv
rtl/sjgl_front.sv
rtl/sjgl_queue.sv
rtl/sjgl_back.sv
rtl/sjis_text_glyph_locator.sv
tb/tb_top.sv
